// File: hdl/mlsp_pkg.sv
// ----------------------------------------------------------------------------
// mlsp_pkg
// Shared types and constants for the multi level set projection block.
// ----------------------------------------------------------------------------
package mlsp_pkg;

    localparam int IDX_W      = 3;
    localparam int RCOUNT_W   = 3;
    localparam int REGION_W   = 2;

    localparam logic [RCOUNT_W-1:0] RCOUNT_RESET = 3'd4;
    localparam logic [RCOUNT_W-1:0] RCOUNT_MIN   = 3'd2;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_adv;

    typedef struct packed {
        logic [IDX_W-1:0] min_region;
        logic [IDX_W-1:0] second_region;
        logic [IDX_W-1:0] hit_region;
        logic             single_inside;
    } t_pick;

endpackage

// File: hdl/mlsp_lane.sv
// ----------------------------------------------------------------------------
// mlsp_lane
// One region lane: inside test at the front, saturating projection at the back.
// ----------------------------------------------------------------------------
module mlsp_lane
    import mlsp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  t_adv                   i_adv,
    input  logic                   i_in_use,
    input  logic [VALUE_WIDTH-1:0] i_phi,
    input  logic [VALUE_WIDTH-1:0] i_corr,
    output logic                   o_le_zero,
    output logic [VALUE_WIDTH-1:0] o_proj
);

    localparam logic [VALUE_WIDTH-1:0] MAX_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] MAX_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic [VALUE_WIDTH-1:0] r_phi2;
    logic [VALUE_WIDTH-1:0] r_phi3;
    logic [VALUE_WIDTH-1:0] r_proj;
    logic [VALUE_WIDTH-1:0] n_proj;
    logic [VALUE_WIDTH:0]   diff;

    assign o_le_zero = $signed(i_phi) <= $signed({VALUE_WIDTH{1'b0}});

    assign diff = {r_phi3[VALUE_WIDTH-1], r_phi3} - {i_corr[VALUE_WIDTH-1], i_corr};

    always_comb begin
        if (!i_in_use) begin
            n_proj = '0;
        end else if (diff[VALUE_WIDTH] != diff[VALUE_WIDTH-1]) begin
            n_proj = diff[VALUE_WIDTH] ? MAX_NEG : MAX_POS;
        end else begin
            n_proj = diff[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s2) begin
            r_phi2 <= i_phi;
        end
        if (i_adv.s3) begin
            r_phi3 <= r_phi2;
        end
        if (i_adv.s4) begin
            r_proj <= n_proj;
        end
    end

    assign o_proj = r_proj;

endmodule

// File: hdl/mlsp_merge.sv
// ----------------------------------------------------------------------------
// mlsp_merge
// Merge stage: two smallest values with strict-less ties, inside region pick.
// ----------------------------------------------------------------------------
module mlsp_merge
    import mlsp_pkg::*;
#(
    parameter int MAX_REGIONS = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [MAX_REGIONS*VALUE_WIDTH-1:0] i_phi,
    input  logic [MAX_REGIONS-1:0]           i_in_use,
    input  logic [MAX_REGIONS-1:0]           i_le_zero,
    output t_pick                            o_pick,
    output logic [VALUE_WIDTH-1:0]           o_min_value,
    output logic [VALUE_WIDTH-1:0]           o_second_value,
    output logic [VALUE_WIDTH-1:0]           o_inside_value
);

    logic signed [VALUE_WIDTH-1:0] phi [MAX_REGIONS];
    logic signed [VALUE_WIDTH-1:0] mv;
    logic signed [VALUE_WIDTH-1:0] sv;
    logic signed [VALUE_WIDTH-1:0] iv;
    logic [IDX_W-1:0]              mr;
    logic [IDX_W-1:0]              sr;
    logic [IDX_W-1:0]              ir;
    logic                          found;
    logic [MAX_REGIONS-1:0]        inside_used;

    t_pick                  r_pick;
    logic [VALUE_WIDTH-1:0] r_min_value;
    logic [VALUE_WIDTH-1:0] r_second_value;
    logic [VALUE_WIDTH-1:0] r_inside_value;

    always_comb begin
        for (int k = 0; k < MAX_REGIONS; k++) begin
            phi[k] = i_phi[k*VALUE_WIDTH +: VALUE_WIDTH];
        end
    end

    always_comb begin
        if (phi[0] < phi[1]) begin
            mv = phi[0]; mr = IDX_W'(0); sv = phi[1]; sr = IDX_W'(1);
        end else begin
            mv = phi[1]; mr = IDX_W'(1); sv = phi[0]; sr = IDX_W'(0);
        end
        for (int k = 2; k < MAX_REGIONS; k++) begin
            if (i_in_use[k]) begin
                if (phi[k] < mv) begin
                    sv = mv; sr = mr; mv = phi[k]; mr = IDX_W'(k);
                end else if (phi[k] < sv) begin
                    sv = phi[k]; sr = IDX_W'(k);
                end
            end
        end
    end

    always_comb begin
        ir    = '0;
        found = 1'b0;
        for (int k = 0; k < MAX_REGIONS; k++) begin
            if (i_in_use[k] && !found) begin
                ir = IDX_W'(k);
            end
            if (k + 1 < MAX_REGIONS) begin
                if (i_in_use[k+1] && i_le_zero[k] && !found) begin
                    ir    = IDX_W'(k);
                    found = 1'b1;
                end
            end
        end
        iv = phi[ir[$clog2(MAX_REGIONS)-1:0]];
    end

    assign inside_used = i_le_zero & i_in_use;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pick.min_region    <= mr;
            r_pick.second_region <= sr;
            r_pick.hit_region    <= ir;
            r_pick.single_inside <= $countones(inside_used) == 1;
            r_min_value          <= mv;
            r_second_value       <= sv;
            r_inside_value       <= iv;
        end
    end

    assign o_pick         = r_pick;
    assign o_min_value    = r_min_value;
    assign o_second_value = r_second_value;
    assign o_inside_value = r_inside_value;

endmodule

// File: hdl/multi_levelset_projection.sv
// ----------------------------------------------------------------------------
// multi_levelset_projection
// Projects one cell's region distances so the two smallest straddle zero.
// ----------------------------------------------------------------------------
//  channel   | direction | word
//  s_axis    | in        | phi_0 .. phi_N-1
//  m_axis    | out       | projected values, minima, correction, inside pick
//  cfg       | in        | region_count
//
//  One word per cycle while the output is not stalled; a word accepted at the
//  input reaches the output register through four register stages.
//  Stages: input register, merge of the lanes, correction add, lane subtract.
//  Each stage holds when the next is full, so words keep entering while a
//  result waits until all four stages hold one. Reset sets region_count to 4
//  and empties the pipeline.
// ----------------------------------------------------------------------------
module multi_levelset_projection
    import mlsp_pkg::*;
#(
    parameter int MAX_REGIONS = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // phi_0 .. phi_(MAX_REGIONS-1), zero padded to bytes
    input  logic [((MAX_REGIONS*VALUE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // out_phi_0 .. out_phi_(MAX_REGIONS-1), min_region, second_region,
    // min_value, second_value, correction, hit_region, inside_value,
    // single_inside, zero padded to bytes
    output logic [(((MAX_REGIONS+4)*VALUE_WIDTH+7+7)/8)*8-1:0] o_m_axis_tdata,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [RCOUNT_W-1:0] i_cfg_data
);

    localparam int RAW_W = (MAX_REGIONS+4)*VALUE_WIDTH + 7;
    localparam int OUT_W = ((RAW_W+7)/8)*8;
    localparam int CNT_W = $clog2(MAX_REGIONS+1);
    localparam int VEC_W = MAX_REGIONS*VALUE_WIDTH;

    logic [RCOUNT_W-1:0]    r_region_count;
    logic [CNT_W-1:0]       eff_regions;
    logic [3:0]             cnt4;
    logic [MAX_REGIONS-1:0] in_use;

    logic                   r_s1_v;
    logic                   r_s2_v;
    logic                   r_s3_v;
    logic                   r_s4_v;
    logic                   rdy1;
    logic                   rdy2;
    logic                   rdy3;
    logic                   rdy4;
    t_adv                   adv;

    logic [VEC_W-1:0]       r_s1_phi;
    logic [MAX_REGIONS-1:0] le_zero;
    logic [VEC_W-1:0]       proj;

    t_pick                  m_pick;
    logic [VALUE_WIDTH-1:0] m_min_value;
    logic [VALUE_WIDTH-1:0] m_second_value;
    logic [VALUE_WIDTH-1:0] m_inside_value;

    t_pick                  r_s3_pick;
    logic [VALUE_WIDTH-1:0] r_s3_min_value;
    logic [VALUE_WIDTH-1:0] r_s3_second_value;
    logic [VALUE_WIDTH-1:0] r_s3_inside_value;
    logic [VALUE_WIDTH-1:0] r_s3_corr;
    logic [VALUE_WIDTH:0]   pair_sum;

    t_pick                  r_s4_pick;
    logic [VALUE_WIDTH-1:0] r_s4_min_value;
    logic [VALUE_WIDTH-1:0] r_s4_second_value;
    logic [VALUE_WIDTH-1:0] r_s4_inside_value;
    logic [VALUE_WIDTH-1:0] r_s4_corr;
    logic [RAW_W-1:0]       raw;

    // region count, clamped to the supported range
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_count <= RCOUNT_RESET;
        end else if (i_cfg_valid) begin
            r_region_count <= i_cfg_data;
        end
    end

    assign cnt4 = {1'b0, r_region_count};

    always_comb begin
        if (cnt4 < 4'(RCOUNT_MIN)) begin
            eff_regions = CNT_W'(RCOUNT_MIN);
        end else if (cnt4 > 4'(MAX_REGIONS)) begin
            eff_regions = CNT_W'(MAX_REGIONS);
        end else begin
            eff_regions = CNT_W'(cnt4);
        end
        for (int k = 0; k < MAX_REGIONS; k++) begin
            in_use[k] = k < int'(eff_regions);
        end
    end

    // pipeline flow control
    assign rdy4 = !r_s4_v || i_m_axis_tready;
    assign rdy3 = !r_s3_v || rdy4;
    assign rdy2 = !r_s2_v || rdy3;
    assign rdy1 = !r_s1_v || rdy2;

    assign adv.s2 = rdy2;
    assign adv.s3 = rdy3;
    assign adv.s4 = rdy4;

    assign o_s_axis_tready = rdy1;
    assign o_m_axis_tvalid = r_s4_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_v <= i_s_axis_tvalid;
            end
            if (rdy2) begin
                r_s2_v <= r_s1_v;
            end
            if (rdy3) begin
                r_s3_v <= r_s2_v;
            end
            if (rdy4) begin
                r_s4_v <= r_s3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_phi <= i_s_axis_tdata[VEC_W-1:0];
        end
    end

    // lanes
    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_lane
        mlsp_lane #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_lane (
            .i_clk     (i_clk),
            .i_adv     (adv),
            .i_in_use  (in_use[g]),
            .i_phi     (r_s1_phi[g*VALUE_WIDTH +: VALUE_WIDTH]),
            .i_corr    (r_s3_corr),
            .o_le_zero (le_zero[g]),
            .o_proj    (proj[g*VALUE_WIDTH +: VALUE_WIDTH])
        );
    end

    mlsp_merge #(
        .MAX_REGIONS (MAX_REGIONS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_merge (
        .i_clk          (i_clk),
        .i_en           (rdy2),
        .i_phi          (r_s1_phi),
        .i_in_use       (in_use),
        .i_le_zero      (le_zero),
        .o_pick         (m_pick),
        .o_min_value    (m_min_value),
        .o_second_value (m_second_value),
        .o_inside_value (m_inside_value)
    );

    // floor of the mean of the two minima
    assign pair_sum = {m_min_value[VALUE_WIDTH-1], m_min_value}
                    + {m_second_value[VALUE_WIDTH-1], m_second_value};

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_pick         <= m_pick;
            r_s3_min_value    <= m_min_value;
            r_s3_second_value <= m_second_value;
            r_s3_inside_value <= m_inside_value;
            r_s3_corr         <= pair_sum[VALUE_WIDTH:1];
        end
        if (rdy4) begin
            r_s4_pick         <= r_s3_pick;
            r_s4_min_value    <= r_s3_min_value;
            r_s4_second_value <= r_s3_second_value;
            r_s4_inside_value <= r_s3_inside_value;
            r_s4_corr         <= r_s3_corr;
        end
    end

    assign raw = {r_s4_pick.single_inside,
                  r_s4_inside_value,
                  r_s4_pick.hit_region[REGION_W-1:0],
                  r_s4_corr,
                  r_s4_second_value,
                  r_s4_min_value,
                  r_s4_pick.second_region[REGION_W-1:0],
                  r_s4_pick.min_region[REGION_W-1:0],
                  proj};

    assign o_m_axis_tdata = OUT_W'(raw);

    a_min_le_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_v |-> $signed(r_s4_min_value) <= $signed(r_s4_second_value))
        else $error("minimum above second minimum");

    a_corr_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_v |-> ($signed(r_s4_min_value) <= $signed(r_s4_corr)
              && $signed(r_s4_corr) <= $signed(r_s4_second_value)))
        else $error("correction outside the two minima");

    a_regions_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_v |-> r_s4_pick.min_region != r_s4_pick.second_region)
        else $error("minimum and second share a region");

    a_single_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4_v && r_s4_pick.single_inside) |-> $signed(r_s4_inside_value) <= 0)
        else $error("single inside region has a positive value");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_s1_v && r_s2_v && r_s3_v && r_s4_v))
        else $error("input stalled with an empty stage");

endmodule
